>>> hw/rtl/i2c_target_register_map_assert.svh
// Assertion macros for the register map block.
// They sample on clk and are disabled while rst_n is low.
`ifndef I2C_TARGET_REGISTER_MAP_ASSERT_SVH
`define I2C_TARGET_REGISTER_MAP_ASSERT_SVH

// Condition holds at every edge.
`define I2CTRM_CHECK(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define I2CTRM_CHECK_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define I2CTRM_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/i2ctrm_pkg.sv
`default_nettype none

package i2ctrm_pkg;

    localparam int REG_COUNT_DEFAULT = 64;

    localparam logic [7:0] ID_BYTE  = 8'hA5;
    localparam logic [7:0] WIN_LOW  = 8'h02;
    localparam logic [7:0] WIN_END  = 8'h2A;
    localparam logic [7:0] CMD_LOW  = 8'hC0;
    localparam logic [7:0] CMD_HIGH = 8'hC9;
    localparam logic [7:0] BUSY_BIT = 8'h04;

    typedef enum logic [1:0] {
        EV_WR_ADDR = 2'd0,
        EV_RD_ADDR = 2'd1,
        EV_TX_REQ  = 2'd2,
        EV_RX_BYTE = 2'd3
    } event_t;

    // Control from the pointer logic to the register store
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic set_busy;
    } store_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/i2ctrm_req_if.sv
`default_nettype none

interface i2ctrm_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink (input valid, input func, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/i2ctrm_rsp_if.sv
`default_nettype none

interface i2ctrm_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       read_valid;
    logic [7:0] command_code;
    logic       command_new;

    modport source (output valid, output read_data, output read_valid,
                    output command_code, output command_new, input ready);
    modport sink (input valid, input read_data, input read_valid,
                  input command_code, input command_new, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/i2ctrm_store.sv
`default_nettype none

module i2ctrm_store
    import i2ctrm_pkg::*;
#(
    parameter int REG_COUNT = REG_COUNT_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire store_ctl_t                   ctl,
    input  wire logic [$clog2(REG_COUNT)-1:0] addr,
    input  wire logic [7:0]                   wr_data,
    output logic [7:0]                        rd_data
);

    localparam int ADDR_W = $clog2(REG_COUNT);

    logic [7:0]           store_mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [REG_COUNT-1:0] valid_next;
    logic                 busy_reg;
    logic                 busy_next;

    logic [7:0] mem_q_reg;
    logic       written_q_reg;
    logic       addr0_q_reg;
    logic       busy_q_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            store_mem[addr] <= wr_data;
        end
    end

    // Registered read; the flags pick the reset value of an entry never written
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            mem_q_reg     <= store_mem[addr];
            written_q_reg <= valid_reg[addr];
            addr0_q_reg   <= (addr == ADDR_W'(0));
            busy_q_reg    <= (addr == ADDR_W'(1)) && busy_reg;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        busy_next  = busy_reg;
        if (ctl.wr_en)
        begin
            valid_next[addr] = 1'b1;
        end
        if (ctl.set_busy)
        begin
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            busy_reg  <= busy_next;
        end
    end

    // Entry 1 is never written by data, so the busy flag alone stands for its bit
    always_comb
    begin
        if (written_q_reg)
        begin
            rd_data = mem_q_reg;
        end
        else if (addr0_q_reg)
        begin
            rd_data = ID_BYTE;
        end
        else
        begin
            rd_data = 8'h00;
        end
        if (busy_q_reg)
        begin
            rd_data = rd_data | BUSY_BIT;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/i2ctrm_ctrl.sv
`default_nettype none

module i2ctrm_ctrl
    import i2ctrm_pkg::*;
#(
    parameter int REG_COUNT = REG_COUNT_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    i2ctrm_req_if.sink                        req,
    i2ctrm_rsp_if.source                      rsp,
    output store_ctl_t                        ctl,
    output logic [$clog2(REG_COUNT)-1:0]      addr,
    output logic [7:0]                        wr_data,
    input  wire logic [7:0]                   rd_data
);

    localparam int ADDR_W = $clog2(REG_COUNT);
    localparam int PTR_W  = $clog2(REG_COUNT + 1);

    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_next;
    logic             loaded_reg;
    logic             loaded_next;
    logic [7:0]       cmd_reg;
    logic [7:0]       cmd_next;

    logic out_valid_reg;
    logic out_valid_next;
    logic rvalid_reg;
    logic rvalid_next;
    logic parked_reg;
    logic parked_next;
    logic cnew_reg;
    logic cnew_next;

    logic   accept;
    event_t ev;
    logic   ptr_in_range;
    logic   ptr_last;
    logic   ptr_in_window;
    logic   byte_is_addr;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign ev        = event_t'(req.func);

    assign ptr_in_range  = 9'(ptr_reg) < 9'(REG_COUNT);
    assign ptr_last      = 9'(ptr_reg) == 9'(REG_COUNT - 1);
    assign ptr_in_window = (9'(ptr_reg) > {1'b0, WIN_LOW}) && (9'(ptr_reg) < {1'b0, WIN_END});
    assign byte_is_addr  = {1'b0, req.rx_byte} < 9'(REG_COUNT);

    assign addr    = ADDR_W'(ptr_reg);
    assign wr_data = req.rx_byte;

    always_comb
    begin
        ptr_next    = ptr_reg;
        loaded_next = loaded_reg;
        cmd_next    = cmd_reg;
        ctl         = '0;
        rvalid_next = rvalid_reg;
        parked_next = parked_reg;
        cnew_next   = cnew_reg;

        if (accept)
        begin
            rvalid_next = 1'b0;
            parked_next = 1'b0;
            cnew_next   = 1'b0;
            case (ev)
                EV_WR_ADDR:
                begin
                    loaded_next = 1'b0;
                end
                EV_RD_ADDR, EV_TX_REQ:
                begin
                    rvalid_next = 1'b1;
                    if (ptr_in_range)
                    begin
                        ctl.rd_en = 1'b1;
                        ptr_next  = ptr_last ? '0 : ptr_reg + PTR_W'(1);
                    end
                    else
                    begin
                        parked_next = 1'b1;
                    end
                end
                EV_RX_BYTE:
                begin
                    if (loaded_reg)
                    begin
                        // Store and advance only inside the writable window
                        if (ptr_in_window && ptr_in_range)
                        begin
                            ctl.wr_en = 1'b1;
                            ptr_next  = ptr_reg + PTR_W'(1);
                        end
                    end
                    else
                    begin
                        loaded_next = 1'b1;
                        if (byte_is_addr)
                        begin
                            ptr_next = PTR_W'(req.rx_byte);
                        end
                        else
                        begin
                            if (req.rx_byte inside {[CMD_LOW:CMD_HIGH]})
                            begin
                                cmd_next     = req.rx_byte;
                                ctl.set_busy = 1'b1;
                                cnew_next    = 1'b1;
                            end
                            // Park the pointer out of range
                            ptr_next = PTR_W'(REG_COUNT);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            loaded_reg    <= 1'b0;
            cmd_reg       <= 8'h00;
            out_valid_reg <= 1'b0;
            rvalid_reg    <= 1'b0;
            parked_reg    <= 1'b0;
            cnew_reg      <= 1'b0;
        end
        else
        begin
            ptr_reg       <= ptr_next;
            loaded_reg    <= loaded_next;
            cmd_reg       <= cmd_next;
            out_valid_reg <= out_valid_next;
            rvalid_reg    <= rvalid_next;
            parked_reg    <= parked_next;
            cnew_reg      <= cnew_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.read_valid   = rvalid_reg;
    assign rsp.read_data    = rvalid_reg ? (parked_reg ? ID_BYTE : rd_data) : 8'h00;
    assign rsp.command_code = cmd_reg;
    assign rsp.command_new  = cnew_reg;

`include "i2c_target_register_map_assert.svh"

    `I2CTRM_CHECK(a_ptr_bound, 9'(ptr_reg) <= 9'(REG_COUNT), "pointer beyond parked value")
    `I2CTRM_CHECK_SAME(a_cmd_no_read, out_valid_reg && cnew_reg, !rvalid_reg,
        "command latched on a read event")
    `I2CTRM_CHECK_SAME(a_cmd_code, out_valid_reg && cnew_reg,
        cmd_reg >= CMD_LOW && cmd_reg <= CMD_HIGH, "latched command outside command range")
    `I2CTRM_CHECK_NEXT(a_wr_addr_clear, accept && ev == EV_WR_ADDR, !loaded_reg,
        "write address match left pointer loaded")

endmodule

`default_nettype wire

>>> hw/rtl/i2c_target_register_map.sv
// Channel  Dir  Payload                                            Handshake
// req      in   func, rx_byte                                      valid/ready
// rsp      out  read_data, read_valid, command_code, command_new   valid/ready
//
// One request is taken per cycle while req.ready is high; its result appears in the next cycle.
// The register store read is registered, matching the registered result.
// rsp holds one result; req.ready drops only while that result is unclaimed.
// Reset is asynchronous; the store needs no clearing pass, per-entry valid
// flags supply the reset contents at once.

`default_nettype none

module i2c_target_register_map
    import i2ctrm_pkg::*;
#(
    parameter int REG_COUNT = REG_COUNT_DEFAULT
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    i2ctrm_req_if.sink   req,
    i2ctrm_rsp_if.source rsp
);

    localparam int ADDR_W = $clog2(REG_COUNT);

    store_ctl_t        ctl;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wr_data;
    logic [7:0]        rd_data;

    i2ctrm_ctrl #(
        .REG_COUNT (REG_COUNT)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .ctl     (ctl),
        .addr    (addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    i2ctrm_store #(
        .REG_COUNT (REG_COUNT)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .addr    (addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire
